// ===== hw/rtl/rta_pkg.sv =====
// ============================================================================
// Region table allocator package
// Shared widths, codes and the command and status types that join the
// controller and the datapath.
// ============================================================================
`default_nettype none

package rta_pkg;

    localparam int ADDR_W          = 32;
    localparam int SIZE_W          = 32;
    localparam int PAGES_W         = 21;
    localparam int OP_W            = 2;
    localparam int ST_W            = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int PAGE_SHIFT      = 12;
    localparam int MAX_REGIONS_DEF = 256;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
    localparam logic [ST_W-1:0] ST_OVERRUN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES = 1'd1;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_FULL,
        RES_MISSING,
        RES_OVERRUN,
        RES_ALLOC,
        RES_RELEASE,
        RES_CHECK
    } res_kind_t;

    typedef struct packed {
        logic      req_load;
        logic      idx_clear;
        logic      vld_clear;
        logic      rd_last;
        logic      search;
        logic      shift;
        logic      hit_capture;
        logic      start_base;
        logic      start_sum;
        logic      calc_off;
        logic      calc_rem;
        logic      calc_chk;
        logic      alloc_commit;
        logic      count_dec;
        logic      res_load;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic hit;
        logic cmp_vld;
        logic last;
        logic shift_done;
        logic fit_ok;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/region_table_allocator_core.sv =====
// ============================================================================
// Region table allocator core
// Bump allocator over one address pool with an ordered table of regions
// that supports allocate, release by start address and a pool range check.
// ============================================================================
//
// Channel  Signals                                        Beat taken when
// -------  ---------------------------------------------  ---------------------
// in       in_valid, in_ready, op, req_size, req_address   in_valid && in_ready
// out      out_valid, out_ready, result_address,           out_valid && out_ready
//          free_pages, legitimate, status
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data       cfg_valid && cfg_ready
//
// Allocate steps through the sum, offset, remainder and fit states (the sum state
// is skipped on an empty table), check through the difference state, and a table-full,
// unused or empty-table release request goes straight to the reply state.
// Release walks the table: the region memory has one read port, so the search and
// the shift that closes the gap each move one entry per cycle.
// One request is in flight at a time; the next is taken as soon as its result
// sits in the output register, even while that beat waits for out_ready.
// Reset empties the table at once; no clearing pass runs.
// The configuration port is always ready.
// ============================================================================
`default_nettype none

module region_table_allocator_core import rta_pkg::*; #(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [SIZE_W-1:0]    req_size,
    input  wire logic [ADDR_W-1:0]    req_address,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ADDR_W-1:0]         result_address,
    output logic [PAGES_W-1:0]        free_pages,
    output logic                      legitimate,
    output logic [ST_W-1:0]           status,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rta_dpath #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_size       (req_size),
        .req_address    (req_address),
        .cmd            (cmd),
        .stat           (stat),
        .result_address (result_address),
        .free_pages     (free_pages),
        .legitimate     (legitimate),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rta_dpath.sv =====
// ============================================================================
// Region table allocator datapath
// Pool registers, region memory with a streaming read port, search and
// shift pointers, the allocate range arithmetic and the result register.
// ============================================================================
`default_nettype none

module rta_dpath import rta_pkg::*; #(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    input  wire logic [SIZE_W-1:0]    req_size,
    input  wire logic [ADDR_W-1:0]    req_address,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    output logic [ADDR_W-1:0]         result_address,
    output logic [PAGES_W-1:0]        free_pages,
    output logic                      legitimate,
    output logic [ST_W-1:0]           status,
    output logic                      out_valid,
    input  wire logic                 out_ready
);

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W = $clog2(MAX_REGIONS);

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } region_t;

    region_t mem [MAX_REGIONS];

    logic [ADDR_W-1:0]  pool_base_reg;
    logic [ADDR_W-1:0]  pool_bytes_reg;
    logic [SIZE_W-1:0]  req_size_reg;
    logic [ADDR_W-1:0]  req_addr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [CNT_W-1:0]   rd_idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [IDX_W-1:0]   cmp_idx_next;
    logic               cmp_vld_reg;
    logic               cmp_vld_next;
    region_t            rd_data_reg;
    logic [ADDR_W-1:0]  start_reg;
    logic [ADDR_W:0]    diff_reg;
    logic               bad_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [ADDR_W-1:0]  res_addr_next;
    logic [PAGES_W-1:0] res_pages_reg;
    logic [PAGES_W-1:0] res_pages_next;
    logic               res_legit_reg;
    logic               res_legit_next;
    logic [ST_W-1:0]    res_st_reg;
    logic [ST_W-1:0]    res_st_next;
    logic               out_valid_reg;

    logic [CNT_W-1:0]   count_m1;
    logic               rd_more;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    region_t            wr_data;
    logic [ADDR_W:0]    rem_calc;
    logic [PAGES_W-1:0] pages_calc;
    logic               out_free;

    assign count_m1 = count_reg - 1'b1;
    assign rd_more  = rd_idx_reg < count_reg;
    assign out_free = !out_valid_reg || out_ready;

    assign rd_en   = cmd.rd_last || ((cmd.search || cmd.shift) && rd_more);
    assign rd_addr = cmd.rd_last ? count_m1[IDX_W-1:0] : rd_idx_reg[IDX_W-1:0];

    assign wr_en   = cmd.alloc_commit || (cmd.shift && cmp_vld_reg);
    assign wr_addr = cmd.alloc_commit ? count_reg[IDX_W-1:0] : cmp_idx_reg;
    assign wr_data = cmd.alloc_commit ? region_t'{start: start_reg, size: req_size_reg}
                                      : rd_data_reg;

    assign rem_calc   = {1'b0, pool_bytes_reg} - {1'b0, diff_reg[ADDR_W-1:0]};
    assign pages_calc = PAGES_W'(size_reg[SIZE_W-1:PAGE_SHIFT])
                      + PAGES_W'(|size_reg[PAGE_SHIFT-1:0]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        if (cmd.idx_clear)
        begin
            rd_idx_next  = '0;
            cmp_vld_next = 1'b0;
        end
        if (cmd.vld_clear)
        begin
            cmp_vld_next = 1'b0;
        end
        if (cmd.search)
        begin
            if (rd_more)
            begin
                rd_idx_next  = rd_idx_reg + 1'b1;
                cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                cmp_vld_next = 1'b1;
            end
            else
            begin
                cmp_vld_next = 1'b0;
            end
        end
        if (cmd.shift)
        begin
            if (cmp_vld_reg)
            begin
                cmp_idx_next = cmp_idx_reg + 1'b1;
            end
            if (rd_more)
            begin
                rd_idx_next  = rd_idx_reg + 1'b1;
                cmp_vld_next = 1'b1;
            end
            else
            begin
                cmp_vld_next = 1'b0;
            end
        end
        if (cmd.alloc_commit)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.count_dec)
        begin
            count_next = count_m1;
        end
    end

    always_comb
    begin
        res_addr_next  = '0;
        res_pages_next = '0;
        res_legit_next = 1'b0;
        res_st_next    = ST_OK;
        case (cmd.res_kind)
            RES_FULL:    res_st_next = ST_FULL;
            RES_MISSING: res_st_next = ST_MISSING;
            RES_OVERRUN: res_st_next = ST_OVERRUN;
            RES_ALLOC:   res_addr_next = start_reg;
            RES_RELEASE:
            begin
                res_addr_next  = req_addr_reg;
                res_pages_next = pages_calc;
            end
            RES_CHECK:
            begin
                res_legit_next = !diff_reg[ADDR_W]
                              && (diff_reg[ADDR_W-1:0] < pool_bytes_reg);
            end
            default:     res_st_next = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= '0;
            pool_bytes_reg <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_POOL_BASE:  pool_base_reg  <= cfg_data;
                    REG_POOL_BYTES: pool_bytes_reg <= cfg_data;
                    default:        pool_base_reg  <= pool_base_reg;
                endcase
            end
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_idx_reg <= cmp_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_size_reg <= req_size;
            req_addr_reg <= req_address;
        end
        if (cmd.hit_capture)
        begin
            size_reg <= rd_data_reg.size;
        end
        if (cmd.start_base)
        begin
            start_reg <= pool_base_reg;
        end
        else if (cmd.start_sum)
        begin
            start_reg <= rd_data_reg.start + rd_data_reg.size;
        end
        if (cmd.calc_off)
        begin
            diff_reg <= {1'b0, start_reg} - {1'b0, pool_base_reg};
        end
        else if (cmd.calc_rem)
        begin
            diff_reg <= rem_calc;
            bad_reg  <= diff_reg[ADDR_W] || rem_calc[ADDR_W];
        end
        else if (cmd.calc_chk)
        begin
            diff_reg <= {1'b0, req_addr_reg} - {1'b0, pool_base_reg};
        end
        if (cmd.res_load)
        begin
            res_addr_reg  <= res_addr_next;
            res_pages_reg <= res_pages_next;
            res_legit_reg <= res_legit_next;
            res_st_reg    <= res_st_next;
        end
    end

    assign stat.count_zero = count_reg == '0;
    assign stat.count_full = count_reg == CNT_W'(MAX_REGIONS);
    assign stat.hit        = cmp_vld_reg && (rd_data_reg.start == req_addr_reg);
    assign stat.cmp_vld    = cmp_vld_reg;
    assign stat.last       = CNT_W'(cmp_idx_reg) == count_m1;
    assign stat.shift_done = (CNT_W'(cmp_idx_reg) == count_m1) && !cmp_vld_reg;
    assign stat.fit_ok     = !bad_reg && !(req_size_reg > diff_reg[ADDR_W-1:0]);
    assign stat.out_free   = out_free;

    assign result_address = res_addr_reg;
    assign free_pages     = res_pages_reg;
    assign legitimate     = res_legit_reg;
    assign status         = res_st_reg;
    assign out_valid      = out_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("Region count exceeds the table depth.");

    a_commit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |-> !stat.count_full)
        else $error("Region written into a full table.");

    a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("Region count did not advance after an allocation.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> out_free)
        else $error("A waiting result beat was overwritten.");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && cmp_vld_reg) |-> (CNT_W'(cmp_idx_reg) < count_m1))
        else $error("Shift wrote beyond the live part of the table.");

endmodule

`default_nettype wire

// ===== hw/rtl/rta_ctrl.sv =====
// ============================================================================
// Region table allocator controller
// Sequences allocate, release and check requests over the datapath and
// hands each result to the output register once it is free.
// ============================================================================
`default_nettype none

module rta_ctrl import rta_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [OP_W-1:0] op,
    output logic                 in_ready,
    input  wire dp_stat_t        stat,
    output dp_cmd_t              cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_A_SUM  = 9'b000000010,
        S_A_OFF  = 9'b000000100,
        S_A_REM  = 9'b000001000,
        S_A_FIT  = 9'b000010000,
        S_SEARCH = 9'b000100000,
        S_SHIFT  = 9'b001000000,
        S_C_DIFF = 9'b010000000,
        S_REPLY  = 9'b100000000
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    res_kind_t kind_reg;
    res_kind_t kind_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.res_kind = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    case (op)
                        OP_ALLOC:
                        begin
                            if (stat.count_full)
                            begin
                                kind_next  = RES_FULL;
                                state_next = S_REPLY;
                            end
                            else if (stat.count_zero)
                            begin
                                cmd.start_base = 1'b1;
                                state_next     = S_A_OFF;
                            end
                            else
                            begin
                                cmd.rd_last = 1'b1;
                                state_next  = S_A_SUM;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (stat.count_zero)
                            begin
                                kind_next  = RES_MISSING;
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                cmd.idx_clear = 1'b1;
                                state_next    = S_SEARCH;
                            end
                        end
                        OP_CHECK:
                        begin
                            state_next = S_C_DIFF;
                        end
                        default:
                        begin
                            kind_next  = RES_NONE;
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_A_SUM:
            begin
                cmd.start_sum = 1'b1;
                state_next    = S_A_OFF;
            end
            S_A_OFF:
            begin
                cmd.calc_off = 1'b1;
                state_next   = S_A_REM;
            end
            S_A_REM:
            begin
                cmd.calc_rem = 1'b1;
                state_next   = S_A_FIT;
            end
            S_A_FIT:
            begin
                if (stat.fit_ok)
                begin
                    cmd.alloc_commit = 1'b1;
                    kind_next        = RES_ALLOC;
                end
                else
                begin
                    kind_next = RES_OVERRUN;
                end
                state_next = S_REPLY;
            end
            S_SEARCH:
            begin
                if (stat.hit)
                begin
                    cmd.hit_capture = 1'b1;
                    cmd.vld_clear   = 1'b1;
                    kind_next       = RES_RELEASE;
                    state_next      = S_SHIFT;
                end
                else if (stat.cmp_vld && stat.last)
                begin
                    kind_next  = RES_MISSING;
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.search = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_REPLY;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_C_DIFF:
            begin
                cmd.calc_chk = 1'b1;
                kind_next    = RES_CHECK;
                state_next   = S_REPLY;
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/region_table_allocator_core_tb.sv =====
// ============================================================================
// Region table allocator core testbench
// Drives allocate, release, check and unused requests through the request
// channel, rewrites the pool registers between phases, and compares every
// result beat field by field with a cycle-free model of the region table.
// Both channels idle at random, and one long output stall backs up the input.
// ============================================================================
`default_nettype none

module region_table_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rta_pkg::*;

    localparam int TABLE_DEPTH = MAX_REGIONS_DEF;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 16;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [PAGES_W-1:0] pages;
        logic               legit;
        logic [ST_W-1:0]    st;
    } region_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [OP_W-1:0]      op = '0;
    logic [SIZE_W-1:0]    req_size = '0;
    logic [ADDR_W-1:0]    req_address = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ADDR_W-1:0]    result_address;
    logic [PAGES_W-1:0]   free_pages;
    logic                 legitimate;
    logic [ST_W-1:0]      status;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;

    logic [ADDR_W-1:0] pool_base_m = '0;
    logic [ADDR_W-1:0] pool_bytes_m = '0;
    logic [ADDR_W-1:0] tbl_start [TABLE_DEPTH];
    logic [SIZE_W-1:0] tbl_size [TABLE_DEPTH];
    int                tbl_count = 0;

    region_result_t pending_results [$];
    int             errors = 0;
    bit             gaps_on = 1'b1;
    int             hold_len = 0;
    int             idle_cycles = 0;

    region_table_allocator_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .req_size       (req_size),
        .req_address    (req_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_address (result_address),
        .free_pages     (free_pages),
        .legitimate     (legitimate),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic region_result_t predict_region_op(logic [OP_W-1:0] o,
                                                         logic [SIZE_W-1:0] sz,
                                                         logic [ADDR_W-1:0] a);
        region_result_t    r;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] off;
        logic [SIZE_W-1:0] rsz;
        int                hit;
        r = '0;
        case (o)
            OP_ALLOC:
            begin
                if (tbl_count >= TABLE_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    if (tbl_count == 0)
                        start = pool_base_m;
                    else
                        start = tbl_start[tbl_count-1] + tbl_size[tbl_count-1];
                    off = start - pool_base_m;
                    if (start < pool_base_m || off > pool_bytes_m || sz > pool_bytes_m - off)
                        r.st = ST_OVERRUN;
                    else
                    begin
                        tbl_start[tbl_count] = start;
                        tbl_size[tbl_count] = sz;
                        tbl_count++;
                        r.addr = start;
                    end
                end
            end
            OP_RELEASE:
            begin
                hit = -1;
                for (int i = 0; i < tbl_count; i++)
                    if (hit < 0 && tbl_start[i] == a)
                        hit = i;
                if (hit < 0)
                    r.st = ST_MISSING;
                else
                begin
                    rsz = tbl_size[hit];
                    r.pages = PAGES_W'(rsz >> PAGE_SHIFT) + PAGES_W'(rsz[PAGE_SHIFT-1:0] != 0);
                    r.addr = a;
                    for (int j = hit; j + 1 < tbl_count; j++)
                    begin
                        tbl_start[j] = tbl_start[j+1];
                        tbl_size[j] = tbl_size[j+1];
                    end
                    tbl_count--;
                end
            end
            OP_CHECK:
                r.legit = (a >= pool_base_m) && ((a - pool_base_m) < pool_bytes_m);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        region_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_POOL_BASE)
                    pool_base_m = cfg_data;
                else
                    pool_bytes_m = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unrequested beat", result_address, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result_address !== want.addr)
                        report_mismatch("result_address", result_address, want.addr);
                    if (free_pages !== want.pages)
                        report_mismatch("free_pages", 32'(free_pages), 32'(want.pages));
                    if (legitimate !== want.legit)
                        report_mismatch("legitimate", 32'(legitimate), 32'(want.legit));
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(predict_region_op(op, req_size, req_address));
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                out_ready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("region_table_allocator_core_tb failed");
        $finish;
    end

    task automatic send_item(logic [OP_W-1:0] o, logic [SIZE_W-1:0] sz,
                             logic [ADDR_W-1:0] a);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        req_size <= sz;
        req_address <= a;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_pool(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] bytes);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_POOL_BASE;
        cfg_data <= base;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_index <= REG_POOL_BYTES;
        cfg_data <= bytes;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_item();
        int                pick;
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] next_start;
        pick = $urandom_range(0, 99);
        sz = $urandom();
        a = $urandom();
        if (pick < 38)
        begin
            if (tbl_count == 0)
                next_start = pool_base_m;
            else
                next_start = tbl_start[tbl_count-1] + tbl_size[tbl_count-1];
            case ($urandom_range(0, 9))
                0: sz = '0;
                1: sz = pool_bytes_m - (next_start - pool_base_m);
                2, 3: sz = $urandom();
                default: sz = $urandom_range(0, 8192);
            endcase
            send_item(OP_ALLOC, sz, a);
        end
        else if (pick < 72)
        begin
            if (tbl_count > 0 && $urandom_range(0, 9) < 8)
                a = tbl_start[$urandom_range(0, tbl_count - 1)];
            send_item(OP_RELEASE, sz, a);
        end
        else if (pick < 95)
        begin
            case ($urandom_range(0, 6))
                0: a = pool_base_m;
                1: a = pool_base_m - 1;
                2: a = pool_base_m + pool_bytes_m;
                3: a = pool_base_m + pool_bytes_m - 1;
                default: a = $urandom();
            endcase
            send_item(OP_CHECK, sz, a);
        end
        else
            send_item(OP_UNUSED, sz, a);
    endtask

    task automatic test_reset_pool();
        send_item(OP_CHECK, '0, '0);
        send_item(OP_ALLOC, 32'd1, '0);
        send_item(OP_ALLOC, '0, '0);
        send_item(OP_ALLOC, '0, 32'hFFFF_FFFF);
        send_item(OP_RELEASE, '0, '0);
        send_item(OP_RELEASE, 32'hFFFF_FFFF, 32'd5);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_RELEASE, '0, '0);
    endtask

    task automatic test_small_pool();
        write_pool(32'h1000_0000, 32'h0001_0000);
        send_item(OP_ALLOC, 32'd4096, '0);
        send_item(OP_ALLOC, 32'd1, '0);
        send_item(OP_ALLOC, 32'd4097, '0);
        send_item(OP_ALLOC, 32'h0001_0000, '0);
        send_item(OP_ALLOC, 32'h0000_DFFE, '0);
        send_item(OP_ALLOC, '0, '0);
        send_item(OP_ALLOC, 32'd1, '0);
        send_item(OP_CHECK, '0, 32'h1000_0000);
        send_item(OP_CHECK, '0, 32'h0FFF_FFFF);
        send_item(OP_CHECK, '0, 32'h1000_FFFF);
        send_item(OP_CHECK, '0, 32'h1001_0000);
        send_item(OP_RELEASE, '0, 32'h1000_1000);
        send_item(OP_RELEASE, '0, 32'h1000_1001);
        send_item(OP_RELEASE, '0, 32'h1000_1000);
        send_item(OP_RELEASE, '0, 32'h1000_0000);
    endtask

    task automatic test_extreme_pool();
        write_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 32'd5, '0);
        send_item(OP_CHECK, '0, 32'hFFFF_FFFF);
        send_item(OP_CHECK, '0, '0);
        send_item(OP_RELEASE, '0, 32'h1000_2002);
        send_item(OP_RELEASE, '0, 32'h1001_0000);
        send_item(OP_ALLOC, 32'hFFFF_FFFF, '0);
        send_item(OP_ALLOC, '0, '0);
        send_item(OP_RELEASE, '0, 32'hFFFF_FFFF);
    endtask

    task automatic test_table_full();
        write_pool($urandom_range(0, 32'h0FFF_FFFF), 32'hF000_0000);
        while (tbl_count < TABLE_DEPTH)
            send_item(OP_ALLOC, $urandom_range(0, 4096), $urandom());
        repeat (3) send_item(OP_ALLOC, $urandom_range(0, 4096), $urandom());
        repeat (90)
        begin
            if (tbl_count > 0 && $urandom_range(0, 9) < 7)
                send_item(OP_RELEASE, $urandom(), tbl_start[$urandom_range(0, tbl_count - 1)]);
            else
                send_random_item();
        end
    endtask

    task automatic test_output_hold();
        drain_results();
        hold_len = 200;
        repeat (12) send_random_item();
    endtask

    task automatic test_random_traffic();
        write_pool($urandom(), 32'h0010_0000);
        repeat (40) send_random_item();
        write_pool('0, 32'hFFFF_FFFF);
        repeat (40) send_random_item();
        write_pool(32'hFFFF_0000, 32'h0000_FFFF);
        repeat (40) send_random_item();
        write_pool($urandom(), $urandom());
        repeat (40) send_random_item();
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        write_pool($urandom_range(0, 32'h7FFF_FFFF), $urandom_range(32'h0100_0000, 32'h7FFF_FFFF));
        repeat (40) send_random_item();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_pool();
        test_small_pool();
        test_extreme_pool();
        test_table_full();
        test_output_hold();
        test_random_traffic();
        test_steady_stream();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("region_table_allocator_core_tb passed");
        else
            $display("region_table_allocator_core_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
